>>> hw/rtl/ecc_pkg.sv
`timescale 1ns / 1ps

package ecc_pkg;

	localparam int unsigned PC_W  = 5;
	localparam int unsigned DAY_W = 21;
	localparam int unsigned ACC_W = 40;
	localparam int unsigned PRD_W = 39;
	localparam int unsigned REM_W = 17;

	localparam logic [11:0] EPOCH_YEAR   = 12'd1970;
	localparam logic [8:0]  EPOCH_R400   = 9'd370;
	localparam logic [8:0]  R400_LAST    = 9'd399;
	localparam logic [8:0]  YLEN_LEAP    = 9'd366;
	localparam logic [8:0]  YLEN_COMMON  = 9'd365;
	localparam logic [3:0]  MONTH_DEC    = 4'd11;
	localparam logic [3:0]  MONTH_ALL    = 4'd12;
	localparam logic [3:0]  MONTH_FEB    = 4'd1;

	// reciprocals of the odd parts of 86400, 3600, 60 and 400
	localparam logic [25:0] RCP_DAY  = 26'd50903317;
	localparam logic [13:0] RCP_HOUR = 14'd9321;
	localparam logic [10:0] RCP_MIN  = 11'd1093;
	localparam logic [8:0]  RCP_400  = 9'd328;

	localparam logic [PC_W-1:0] PC_TO_CAL = 5'd13;
	localparam logic [PC_W-1:0] PC_START  = 5'd0;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_DIV,
		OP_REM,
		OP_SAVE_DAYS,
		OP_SAVE_HOUR,
		OP_SAVE_MIN,
		OP_LEAP,
		OP_YADD,
		OP_YSUB,
		OP_MADD,
		OP_MSUB,
		OP_DAYADD,
		OP_MULACC,
		OP_DONE
	} op_t;

	typedef enum logic [3:0] {
		K_NONE,
		K_DAY,
		K_HOUR,
		K_MIN,
		K_SEC,
		K_D86400,
		K_D3600,
		K_D60,
		K_D400
	} ksel_t;

	typedef enum logic [1:0] {
		J_NEXT,
		J_LOOP,
		J_CMD,
		J_GOTO
	} jmp_t;

	typedef struct packed {
		op_t             op;
		ksel_t           ksel;
		jmp_t            jmp;
		logic [PC_W-1:0] tgt;
	} ucode_t;

	// leap test on a year taken modulo 400
	function automatic logic leap400(input logic [8:0] r);
		return (r[1:0] == 2'd0) && (r != 9'd100) && (r != 9'd200) && (r != 9'd300);
	endfunction

	function automatic logic [4:0] month_len(input logic [3:0] m);
		logic [4:0] len;
		unique case (m)
			4'd1:                      len = 5'd28;
			4'd3, 4'd5, 4'd8, 4'd10:   len = 5'd30;
			default:                   len = 5'd31;
		endcase
		return len;
	endfunction

	function automatic logic [REM_W-1:0] divisor(input ksel_t k);
		logic [REM_W-1:0] d;
		unique case (k)
			K_D86400: d = 17'd86400;
			K_D3600:  d = 17'd3600;
			K_D60:    d = 17'd60;
			K_D400:   d = 17'd400;
			default:  d = 17'd1;
		endcase
		return d;
	endfunction

	function automatic logic [REM_W-1:0] mul_const(input ksel_t k);
		logic [REM_W-1:0] c;
		unique case (k)
			K_DAY:   c = 17'd86400;
			K_HOUR:  c = 17'd3600;
			K_MIN:   c = 17'd60;
			K_SEC:   c = 17'd1;
			default: c = 17'd0;
		endcase
		return c;
	endfunction

	// control store
	function automatic ucode_t ucode(input logic [PC_W-1:0] pc);
		ucode_t uc;
		unique case (pc)
			5'd0:    uc = '{OP_NONE,      K_NONE,   J_CMD,  PC_TO_CAL};
			// calendar to seconds
			5'd1:    uc = '{OP_DIV,       K_D400,   J_NEXT, pc};
			5'd2:    uc = '{OP_REM,       K_D400,   J_NEXT, pc};
			5'd3:    uc = '{OP_LEAP,      K_NONE,   J_NEXT, pc};
			5'd4:    uc = '{OP_YADD,      K_NONE,   J_LOOP, pc};
			5'd5:    uc = '{OP_MADD,      K_NONE,   J_LOOP, pc};
			5'd6:    uc = '{OP_DAYADD,    K_NONE,   J_NEXT, pc};
			5'd7:    uc = '{OP_MULACC,    K_DAY,    J_NEXT, pc};
			5'd8:    uc = '{OP_MULACC,    K_HOUR,   J_NEXT, pc};
			5'd9:    uc = '{OP_MULACC,    K_MIN,    J_NEXT, pc};
			5'd10:   uc = '{OP_MULACC,    K_SEC,    J_NEXT, pc};
			5'd11:   uc = '{OP_MULACC,    K_NONE,   J_NEXT, pc};
			5'd12:   uc = '{OP_DONE,      K_NONE,   J_LOOP, pc};
			// seconds to calendar
			5'd13:   uc = '{OP_DIV,       K_D86400, J_NEXT, pc};
			5'd14:   uc = '{OP_REM,       K_D86400, J_NEXT, pc};
			5'd15:   uc = '{OP_SAVE_DAYS, K_NONE,   J_NEXT, pc};
			5'd16:   uc = '{OP_DIV,       K_D3600,  J_NEXT, pc};
			5'd17:   uc = '{OP_REM,       K_D3600,  J_NEXT, pc};
			5'd18:   uc = '{OP_SAVE_HOUR, K_NONE,   J_NEXT, pc};
			5'd19:   uc = '{OP_DIV,       K_D60,    J_NEXT, pc};
			5'd20:   uc = '{OP_REM,       K_D60,    J_NEXT, pc};
			5'd21:   uc = '{OP_SAVE_MIN,  K_NONE,   J_NEXT, pc};
			5'd22:   uc = '{OP_YSUB,      K_NONE,   J_LOOP, pc};
			5'd23:   uc = '{OP_LEAP,      K_NONE,   J_NEXT, pc};
			5'd24:   uc = '{OP_MSUB,      K_NONE,   J_LOOP, pc};
			5'd25:   uc = '{OP_DONE,      K_NONE,   J_LOOP, pc};
			default: uc = '{OP_NONE,      K_NONE,   J_GOTO, PC_START};
		endcase
		return uc;
	endfunction

endpackage

>>> hw/rtl/epoch_calendar_converter.sv
`timescale 1ns / 1ps

// calendar to seconds: year divide, leap test, year and month count loops, day add, multiply-accumulate
// seconds to calendar: divides by 86400, 3600 and 60, then the year and month count loops
// the count loops step one year or one month per cycle; a divide takes two steps
// one request at a time; the next is taken while a result waits in the output register
// arst_n clears the sequencer and the output valid; no store needs clearing
module epoch_calendar_converter import ecc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// epoch_seconds, cal_year, cal_month, cal_day, cal_hour, cal_minute, cal_second, pad
	input  logic [71:0] s_axis_tdata,
	// command
	input  logic        s_axis_tuser,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// out_seconds, out_year, out_month, out_day, out_hour, out_minute, out_second, pad
	output logic [71:0] m_axis_tdata,
	// wrapped
	output logic        m_axis_tuser
);

	logic            busy_q;
	logic [PC_W-1:0] pc_q;
	logic            out_vld_q;

	logic                    cmd_q;
	logic [31:0]             a_q;
	logic [REM_W-1:0]        r_q;
	logic [15:0]             quo_q;
	logic signed [DAY_W-1:0] d_q;
	logic [11:0]             y_q;
	logic [8:0]              r400_q;
	logic [3:0]              m_q;
	logic                    leap_q;
	logic [11:0]             year_q;
	logic [3:0]              months_q;
	logic [4:0]              day_q;
	logic [4:0]              hour_q;
	logic [5:0]              min_q;
	logic [5:0]              sec_q;
	logic signed [PRD_W-1:0] prod_q;
	logic signed [ACC_W-1:0] acc_q;
	logic [69:0]             odata_q;
	logic                    owrap_q;

	ucode_t                  ctl;
	logic                    s_acc;
	logic                    stall;
	logic                    act;
	logic [PC_W-1:0]         pc_nxt;
	logic [50:0]             qp_day;
	logic [26:0]             qp_hour;
	logic [20:0]             qp_min;
	logic [16:0]             qp_y400;
	logic [15:0]             q_nxt;
	logic [31:0]             qd;
	logic [31:0]             rdiff;
	logic [8:0]              ylen;
	logic [DAY_W-1:0]        dim;
	logic signed [DAY_W-1:0] mopnd;
	logic signed [PRD_W-1:0] mprod;
	logic [3:0]              in_month;
	logic [3:0]              in_months;

	assign ctl   = ucode(pc_q);
	assign s_acc = s_axis_tvalid && s_axis_tready;
	assign stall = out_vld_q && !m_axis_tready;

	assign s_axis_tready = !busy_q;
	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = {2'b00, odata_q};
	assign m_axis_tuser  = owrap_q;

	// quotient by reciprocal multiply, power-of-two factor shifted out first
	assign qp_day  = {25'd0, a_q[31:7]} * {25'd0, RCP_DAY};
	assign qp_hour = {14'd0, a_q[16:4]} * {13'd0, RCP_HOUR};
	assign qp_min  = {11'd0, a_q[11:2]} * {10'd0, RCP_MIN};
	assign qp_y400 = {9'd0, a_q[11:4]} * {8'd0, RCP_400};

	always_comb begin
		unique case (ctl.ksel)
			K_D86400: q_nxt = qp_day[50:35];
			K_D3600:  q_nxt = {10'd0, qp_hour[26:21]};
			K_D60:    q_nxt = {9'd0, qp_min[20:14]};
			K_D400:   q_nxt = {12'd0, qp_y400[16:13]};
			default:  q_nxt = '0;
		endcase
	end

	// remainder from the registered quotient
	assign qd    = {16'd0, quo_q} * {15'd0, divisor(ctl.ksel)};
	assign rdiff = a_q - qd;

	assign ylen = leap400(r400_q) ? YLEN_LEAP : YLEN_COMMON;
	assign dim  = DAY_W'(month_len(m_q)) + DAY_W'((m_q == MONTH_FEB) && leap_q);

	always_comb begin
		unique case (ctl.ksel)
			K_DAY:   mopnd = d_q;
			K_HOUR:  mopnd = $signed(DAY_W'(hour_q));
			K_MIN:   mopnd = $signed(DAY_W'(min_q));
			K_SEC:   mopnd = $signed(DAY_W'(sec_q));
			default: mopnd = '0;
		endcase
	end

	assign mprod = PRD_W'(mopnd) * PRD_W'($signed({1'b0, mul_const(ctl.ksel)}));

	assign in_month  = s_axis_tdata[47:44];
	assign in_months = (in_month == 4'd0) ? 4'd0 :
		((in_month - 4'd1) > MONTH_ALL) ? MONTH_ALL : (in_month - 4'd1);

	always_comb begin
		unique case (ctl.op)
			OP_YSUB: act = d_q >= $signed(DAY_W'(ylen));
			OP_YADD: act = y_q < year_q;
			OP_MSUB: act = (m_q < MONTH_DEC) && (d_q >= $signed(dim));
			OP_MADD: act = m_q < months_q;
			OP_DONE: act = stall;
			default: act = 1'b0;
		endcase
	end

	always_comb begin
		unique case (ctl.jmp)
			J_LOOP:  pc_nxt = act ? ctl.tgt : pc_q + 5'd1;
			J_CMD:   pc_nxt = cmd_q ? ctl.tgt : pc_q + 5'd1;
			J_GOTO:  pc_nxt = ctl.tgt;
			default: pc_nxt = pc_q + 5'd1;
		endcase
	end

	// sequencer and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= 1'b0;
			pc_q      <= PC_START;
			out_vld_q <= 1'b0;
		end else begin
			if (busy_q && ctl.op == OP_DONE && !stall) begin
				out_vld_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_vld_q <= 1'b0;
			end
			if (s_acc) begin
				busy_q <= 1'b1;
				pc_q   <= PC_START;
			end else if (busy_q) begin
				pc_q <= pc_nxt;
				if (ctl.op == OP_DONE && !stall) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (s_acc) begin
			cmd_q    <= s_axis_tuser;
			a_q      <= s_axis_tuser ? s_axis_tdata[31:0] : {20'd0, s_axis_tdata[43:32]};
			r_q      <= '0;
			d_q      <= '0;
			y_q      <= EPOCH_YEAR;
			r400_q   <= EPOCH_R400;
			m_q      <= '0;
			year_q   <= s_axis_tdata[43:32];
			months_q <= in_months;
			day_q    <= s_axis_tdata[52:48];
			hour_q   <= s_axis_tdata[57:53];
			min_q    <= s_axis_tdata[63:58];
			sec_q    <= s_axis_tdata[69:64];
			prod_q   <= '0;
			acc_q    <= '0;
		end else if (busy_q) begin
			case (ctl.op)
				OP_DIV: begin
					quo_q <= q_nxt;
				end
				OP_REM: begin
					a_q <= {16'd0, quo_q};
					r_q <= rdiff[REM_W-1:0];
				end
				OP_SAVE_DAYS: begin
					d_q <= $signed(a_q[DAY_W-1:0]);
					a_q <= 32'(r_q);
					r_q <= '0;
				end
				OP_SAVE_HOUR: begin
					hour_q <= a_q[4:0];
					a_q    <= 32'(r_q);
					r_q    <= '0;
				end
				OP_SAVE_MIN: begin
					min_q <= a_q[5:0];
					sec_q <= r_q[5:0];
				end
				OP_LEAP: begin
					leap_q <= leap400(cmd_q ? r400_q : r_q[8:0]);
				end
				OP_YADD, OP_YSUB: begin
					if (act) begin
						d_q    <= (ctl.op == OP_YADD) ? d_q + $signed(DAY_W'(ylen))
							: d_q - $signed(DAY_W'(ylen));
						y_q    <= y_q + 12'd1;
						r400_q <= (r400_q == R400_LAST) ? 9'd0 : r400_q + 9'd1;
					end
				end
				OP_MADD, OP_MSUB: begin
					if (act) begin
						d_q <= (ctl.op == OP_MADD) ? d_q + $signed(dim) : d_q - $signed(dim);
						m_q <= m_q + 4'd1;
					end
				end
				OP_DAYADD: begin
					d_q <= d_q + $signed(DAY_W'(day_q)) - $signed(DAY_W'(1));
				end
				OP_MULACC: begin
					acc_q  <= acc_q + ACC_W'(prod_q);
					prod_q <= mprod;
				end
				default: begin
				end
			endcase
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (busy_q && ctl.op == OP_DONE && !stall) begin
			if (cmd_q) begin
				odata_q <= {sec_q, min_q, hour_q, 5'(d_q[4:0] + 5'd1), 4'(m_q + 4'd1),
					y_q, 32'd0};
				owrap_q <= 1'b0;
			end else begin
				odata_q <= {38'd0, acc_q[31:0]};
				owrap_q <= acc_q[ACC_W-1:32] != '0;
			end
		end
	end

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		s_acc |=> busy_q && pc_q == PC_START)
		else $error("accepted request did not start the sequencer");

	a_result_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_vld_q) |-> $past(busy_q) && $past(ctl.op == OP_DONE))
		else $error("result raised outside the final step");

	a_days_in_year: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q && ctl.op == OP_MSUB |-> d_q >= 0 && d_q < $signed(DAY_W'(YLEN_LEAP)))
		else $error("day count left over after year loop is out of range");

endmodule

>>> sim/epoch_calendar_checker.sv
`timescale 1ns / 1ps

package ecc_tb_pkg;

	typedef enum logic {
		CMD_TO_SECONDS  = 1'b0,
		CMD_TO_CALENDAR = 1'b1
	} conv_cmd_t;

	// request beat, lowest field last
	typedef struct packed {
		logic [1:0]  pad;
		logic [5:0]  cal_second;
		logic [5:0]  cal_minute;
		logic [4:0]  cal_hour;
		logic [4:0]  cal_day;
		logic [3:0]  cal_month;
		logic [11:0] cal_year;
		logic [31:0] epoch_seconds;
	} conv_req_t;

	// result beat, lowest field last
	typedef struct packed {
		logic [1:0]  pad;
		logic [5:0]  out_second;
		logic [5:0]  out_minute;
		logic [4:0]  out_hour;
		logic [4:0]  out_day;
		logic [3:0]  out_month;
		logic [11:0] out_year;
		logic [31:0] out_seconds;
	} conv_res_t;

endpackage

module epoch_calendar_checker import ecc_tb_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	input  logic        s_axis_tready,
	input  logic [71:0] s_axis_tdata,
	input  logic        s_axis_tuser,
	input  logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	input  logic [71:0] m_axis_tdata,
	input  logic        m_axis_tuser,
	output int          fails,
	output int          pending
);

	localparam int unsigned START_YEAR   = 1970;
	localparam longint      DAY_SECS     = 86400;
	localparam longint      HOUR_SECS    = 3600;
	localparam longint      MINUTE_SECS  = 60;
	localparam int unsigned LAST_MONTH   = 11;
	localparam int unsigned FEBRUARY     = 1;
	localparam int unsigned MONTH_DAYS [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

	typedef struct packed {
		logic      wrapped;
		conv_res_t fields;
	} conversion_t;

	conversion_t expected_conversions [$];

	initial begin
		fails = 0;
		pending = 0;
	end

	function automatic bit is_leap(input int unsigned y);
		return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
	endfunction

	function automatic int unsigned year_days(input int unsigned y);
		return is_leap(y) ? 366 : 365;
	endfunction

	function automatic conversion_t convert_request(input conv_cmd_t cmd, input conv_req_t rq);
		conversion_t c;
		int unsigned rest;
		int unsigned y;
		int unsigned m;
		int unsigned dim;
		int unsigned months;
		longint      days;
		longint      total;
		c = '0;
		if (cmd == CMD_TO_CALENDAR) begin
			rest = rq.epoch_seconds;
			c.fields.out_second = 6'(rest % 60);
			rest = rest / 60;
			c.fields.out_minute = 6'(rest % 60);
			rest = rest / 60;
			c.fields.out_hour = 5'(rest % 24);
			rest = rest / 24;
			y = START_YEAR;
			while (rest >= year_days(y)) begin
				rest = rest - year_days(y);
				y++;
			end
			for (m = 0; m < LAST_MONTH; m++) begin
				dim = MONTH_DAYS[m] + ((m == FEBRUARY && is_leap(y)) ? 1 : 0);
				if (rest < dim)
					break;
				rest = rest - dim;
			end
			c.fields.out_year  = 12'(y);
			c.fields.out_month = 4'(m + 1);
			c.fields.out_day   = 5'(rest + 1);
		end else begin
			days = 0;
			for (y = START_YEAR; y < rq.cal_year; y++)
				days += year_days(y);
			months = (rq.cal_month == 0) ? 0 : rq.cal_month - 1;
			if (months > 12)
				months = 12;
			for (m = 0; m < months; m++) begin
				days += MONTH_DAYS[m];
				if (m == FEBRUARY && is_leap(rq.cal_year))
					days++;
			end
			days += longint'(rq.cal_day) - 1;
			total = days * DAY_SECS + longint'(rq.cal_hour) * HOUR_SECS
				+ longint'(rq.cal_minute) * MINUTE_SECS + longint'(rq.cal_second);
			c.fields.out_seconds = total[31:0];
			c.wrapped = (total < 0) || (total > 64'sh0_FFFF_FFFF);
		end
		return c;
	endfunction

	task automatic report_mismatch(input string what, input longint got, input longint want);
		$display("%0t ns: %s got %0d expected %0d", $time, what, got, want);
		fails++;
	endtask

	always @(posedge clk) begin : watch
		conversion_t want;
		conv_res_t   got;
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				got = m_axis_tdata;
				if (expected_conversions.size() == 0) begin
					report_mismatch("unexpected result beat, out_seconds", got.out_seconds, 0);
				end else begin
					want = expected_conversions.pop_front();
					if (got.out_seconds !== want.fields.out_seconds)
						report_mismatch("out_seconds", got.out_seconds, want.fields.out_seconds);
					if (got.out_year !== want.fields.out_year)
						report_mismatch("out_year", got.out_year, want.fields.out_year);
					if (got.out_month !== want.fields.out_month)
						report_mismatch("out_month", got.out_month, want.fields.out_month);
					if (got.out_day !== want.fields.out_day)
						report_mismatch("out_day", got.out_day, want.fields.out_day);
					if (got.out_hour !== want.fields.out_hour)
						report_mismatch("out_hour", got.out_hour, want.fields.out_hour);
					if (got.out_minute !== want.fields.out_minute)
						report_mismatch("out_minute", got.out_minute, want.fields.out_minute);
					if (got.out_second !== want.fields.out_second)
						report_mismatch("out_second", got.out_second, want.fields.out_second);
					if (m_axis_tuser !== want.wrapped)
						report_mismatch("wrapped", m_axis_tuser, want.wrapped);
				end
			end
			if (s_axis_tvalid && s_axis_tready)
				expected_conversions.push_back(convert_request(conv_cmd_t'(s_axis_tuser), s_axis_tdata));
			pending = expected_conversions.size();
		end
	end

endmodule

>>> sim/epoch_calendar_converter_test.sv
`timescale 1ns / 1ps

module epoch_calendar_converter_test;
	import ecc_tb_pkg::*;

	localparam int     ITEMS       = 2000;
	localparam int     IDLE_PCT    = 27;
	localparam int     DRAIN       = 300;
	localparam longint CYCLE_LIMIT = 20_000_000;
	localparam int     STEADY_FROM = 800;
	localparam int     STEADY_TO   = 1100;

	logic        clk           = 1'b0;
	logic        arst_n        = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [71:0] s_axis_tdata  = '0;
	logic        s_axis_tuser  = 1'b0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [71:0] m_axis_tdata;
	logic        m_axis_tuser;
	int          fails;
	int          pending;
	bit          steady = 1'b0;
	longint      cycles = 0;

	always #4 clk = ~clk;

	always @(posedge clk) begin
		cycles = cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	always @(negedge clk) begin
		m_axis_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
	end

	epoch_calendar_converter dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	epoch_calendar_checker checker_i (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.fails         (fails),
		.pending       (pending)
	);

	// unused fields carry noise so that their bits toggle; pad is held at zero
	function automatic conv_req_t noise_req();
		conv_req_t rq;
		rq = 72'({$urandom, $urandom, $urandom});
		rq.pad = '0;
		return rq;
	endfunction

	// called at a falling edge, returns at the falling edge after the beat is taken
	task automatic push_beat(input conv_cmd_t cmd, input conv_req_t rq);
		while (!steady && $urandom_range(99) < IDLE_PCT) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tdata  <= rq;
		s_axis_tuser  <= cmd;
		s_axis_tvalid <= 1'b1;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic ask_calendar(input logic [31:0] secs);
		conv_req_t rq;
		rq = noise_req();
		rq.epoch_seconds = secs;
		push_beat(CMD_TO_CALENDAR, rq);
	endtask

	task automatic ask_seconds(input int y, input int mo, input int d, input int h,
			input int mi, input int s);
		conv_req_t rq;
		rq = noise_req();
		rq.cal_year   = 12'(y);
		rq.cal_month  = 4'(mo);
		rq.cal_day    = 5'(d);
		rq.cal_hour   = 5'(h);
		rq.cal_minute = 6'(mi);
		rq.cal_second = 6'(s);
		push_beat(CMD_TO_SECONDS, rq);
	endtask

	initial begin : stimulus
		int sel;
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// epoch start, last second, leap days, century years and out-of-range fields
		ask_calendar(32'd0);
		ask_calendar(32'hFFFF_FFFF);
		ask_calendar(32'd951782400);
		ask_calendar(32'd951868799);
		ask_calendar(32'd4107542399);
		ask_calendar(32'd4107542400);
		ask_calendar(32'd68169600);
		ask_calendar(32'd978307199);
		ask_calendar(32'h8000_0000);
		ask_seconds(1970, 1, 1, 0, 0, 0);
		ask_seconds(2106, 2, 7, 6, 28, 15);
		ask_seconds(2106, 2, 7, 6, 28, 16);
		ask_seconds(2106, 12, 31, 23, 59, 59);
		ask_seconds(4095, 15, 31, 31, 63, 63);
		ask_seconds(0, 0, 0, 0, 0, 0);
		ask_seconds(1969, 1, 1, 0, 0, 0);
		ask_seconds(1970, 1, 0, 0, 0, 0);
		ask_seconds(2024, 0, 15, 12, 0, 0);
		ask_seconds(2024, 13, 1, 0, 0, 0);
		ask_seconds(2023, 2, 31, 24, 60, 60);
		ask_seconds(2000, 3, 1, 0, 0, 0);
		ask_seconds(2100, 3, 1, 0, 0, 0);

		for (int i = 0; i < ITEMS; i++) begin
			steady = (i >= STEADY_FROM) && (i < STEADY_TO);
			sel = $urandom_range(99);
			if ($urandom_range(1) == 1) begin
				if (sel < 70)
					ask_calendar($urandom);
				else
					ask_calendar($urandom_range(49710) * 86400
						+ (($urandom_range(1) == 1) ? 86399 : $urandom_range(3)));
			end else if (sel < 85) begin
				ask_seconds($urandom_range(2106, 1970), $urandom_range(12, 1),
					$urandom_range(31, 1), $urandom_range(23), $urandom_range(59),
					$urandom_range(59));
			end else if (sel < 97) begin
				ask_seconds($urandom_range(2200, 1900), $urandom_range(15), $urandom_range(31),
					$urandom_range(31), $urandom_range(63), $urandom_range(63));
			end else begin
				ask_seconds($urandom_range(4095), $urandom_range(15), $urandom_range(31),
					$urandom_range(31), $urandom_range(63), $urandom_range(63));
			end
		end
		steady = 1'b0;
		s_axis_tvalid <= 1'b0;

		while (pending != 0)
			@(posedge clk);
		repeat (DRAIN) @(posedge clk);

		if (fails == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

>>> sim.f
hw/rtl/ecc_pkg.sv
hw/rtl/epoch_calendar_converter.sv
sim/epoch_calendar_checker.sv
sim/epoch_calendar_converter_test.sv
